// ----- rtl/core/bfg_pkg.sv -----
// Shared types and constants of the grayscale bilateral filter.
package bfg_pkg;

  localparam int ACTION_W = 2;
  localparam int INDEX_W = 8;
  localparam int WEIGHT_IN_W = 16;
  localparam int PIXEL_W = 8;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int RADIUS_REG_W = 2;

  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_W = 12;
  localparam int RANGE_DEPTH = 256;
  localparam int QUO_W = 9;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RST = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [RADIUS_REG_W-1:0] RADIUS_RST = 2'd3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RANGE   = 2'd0,
    ACT_SPATIAL = 2'd1,
    ACT_PIXEL   = 2'd2,
    ACT_DRAIN   = 2'd3
  } action_e;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

endpackage

// ----- rtl/core/bilateral_filter_gray_top.sv -----
// Streaming grayscale bilateral filter: line store, weight tables, shared MAC and divider.
// Flow: table loads and pixels that complete no output leave the block idle. An item that yields an
//   output runs one pass of the shared multiplier and accumulator per window tap (line store
//   read, table reads, multiply, accumulate), then a 9-step restoring divide, and waits in ST_DONE
//   while the result register is held. in_stall_o is high until it is idle again; no overlap.
// Reset: counters, drain flag and configuration registers reset asynchronously (rst_ni low).
//   Line store and weight tables are not cleared and must be loaded before use.
module bilateral_filter_gray_top #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_RADIUS = 3,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [bfg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bfg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bfg_pkg::ACTION_W-1:0]      action_i,
  input  logic [bfg_pkg::INDEX_W-1:0]       table_index_i,
  input  logic [bfg_pkg::WEIGHT_IN_W-1:0]   weight_i,
  input  logic [bfg_pkg::PIXEL_W-1:0]       pixel_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bfg_pkg::PIXEL_W-1:0]       out_pixel_o,
  output logic                              frame_last_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW_W = COL_W + 1;
  localparam int LS_ROWS = 2 * MAX_RADIUS + 2;
  localparam int RING_W = $clog2(LS_ROWS);
  localparam int LS_AW = RING_W + COL_W;
  localparam int LS_DEPTH = 1 << LS_AW;
  localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
  localparam int SP_DEPTH = SIDE_MAX * SIDE_MAX;
  localparam int SP_W = $clog2(SP_DEPTH);
  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int SIDE_W = $clog2(SIDE_MAX);
  localparam int TAP_W = $clog2(SP_DEPTH + 1);
  localparam int DEN_W = WEIGHT_BITS + TAP_W;
  localparam int NUM_W = DEN_W + bfg_pkg::PIXEL_W;
  localparam int REM_W = NUM_W + 1;
  localparam int LEAD_W = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int ROW_W = bfg_pkg::ROW_W;
  localparam int HR_W = bfg_pkg::HEIGHT_REG_W;
  localparam int QUO_W = bfg_pkg::QUO_W;
  localparam int CNT_W = $clog2(QUO_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CTR,       // center address out
    ST_CTR_CAP,   // capture center, first tap address out
    ST_TAP_RD,    // tap address out
    ST_TAP_DIFF,  // |p - center| to range table, tap index to spatial table
    ST_TAP_MUL,   // spatial * range
    ST_TAP_ACC,   // num += p*c, den += c
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [bfg_pkg::WIDTH_REG_W-1:0]  width_q;
  logic [bfg_pkg::HEIGHT_REG_W-1:0] height_q;
  logic [bfg_pkg::RADIUS_REG_W-1:0] radius_q;

  // frame position
  logic [ROW_W-1:0]  in_row_q, out_row_q;
  logic [COL_W-1:0]  in_col_q, out_col_q;
  logic [LEAD_W-1:0] lead_q;   // inputs taken minus outputs given in this frame
  logic              drain_q;

  // window walk and arithmetic
  logic [SIDE_W-1:0]         dy_q, dx_q;
  logic [SP_W-1:0]           ti_q;
  logic [7:0]                center_q;
  logic [2*WEIGHT_BITS-1:0]  prod_q;
  logic [NUM_W-1:0]          num_q;
  logic [DEN_W-1:0]          den_q;
  logic [REM_W-1:0]          rem_q;
  logic [NUM_W-1:0]          dsh_q;
  logic [QUO_W-1:0]          quo_q;
  logic [CNT_W-1:0]          cnt_q;

  // result register
  logic                      out_valid_q;
  logic [7:0]                out_pixel_q;
  logic                      frame_last_q;

  // memories
  logic [7:0]               ls_mem [LS_DEPTH];
  logic [WEIGHT_BITS-1:0]   rng_mem [bfg_pkg::RANGE_DEPTH];
  logic [WEIGHT_BITS-1:0]   sp_mem [SP_DEPTH];
  logic [7:0]               ls_rdata_q;
  logic [WEIGHT_BITS-1:0]   rng_rdata_q, sp_rdata_q;

  // effective configuration (zero means one, large values saturate)
  logic [EW_W-1:0]   eff_w;
  logic [HR_W-1:0]   eff_h;
  logic [RAD_W-1:0]  eff_r;
  logic [LEAD_W-1:0] delay;
  logic [SIDE_W-1:0] two_r;

  always_comb begin
    if (width_q == '0) begin
      eff_w = EW_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HR_W'(1);
    end else if (32'(height_q) > bfg_pkg::HEIGHT_LIMIT) begin
      eff_h = HR_W'(bfg_pkg::HEIGHT_LIMIT);
    end else begin
      eff_h = height_q;
    end
    if (radius_q == '0) begin
      eff_r = RAD_W'(1);
    end else if (32'(radius_q) > MAX_RADIUS) begin
      eff_r = RAD_W'(MAX_RADIUS);
    end else begin
      eff_r = RAD_W'(radius_q);
    end
  end

  // output (row, col) leaves once input reaches R rows and R columns beyond it
  assign delay = LEAD_W'(32'(eff_r) * 32'(eff_w)) + LEAD_W'(eff_r);
  assign two_r = SIDE_W'(32'(eff_r) * 2);

  // replicated-edge tap coordinates
  logic signed [ROW_W+1:0] ys;
  logic signed [COL_W+1:0] xs;
  logic [ROW_W-1:0]        yy;
  logic [COL_W-1:0]        xx;

  always_comb begin
    ys = $signed({2'b00, out_row_q}) + $signed((ROW_W+2)'(dy_q))
       - $signed((ROW_W+2)'(eff_r));
    xs = $signed({2'b00, out_col_q}) + $signed((COL_W+2)'(dx_q))
       - $signed((COL_W+2)'(eff_r));
    if (ys < 0) begin
      yy = '0;
    end else if (ys >= $signed({1'b0, eff_h})) begin
      yy = ROW_W'(eff_h - HR_W'(1));
    end else begin
      yy = ys[ROW_W-1:0];
    end
    if (xs < 0) begin
      xx = '0;
    end else if (xs >= $signed({1'b0, eff_w})) begin
      xx = COL_W'(eff_w - EW_W'(1));
    end else begin
      xx = xs[COL_W-1:0];
    end
  end

  logic [LS_AW-1:0] ls_raddr, ls_waddr;
  logic [7:0]       diff;
  logic             in_acc;
  logic             ls_we;
  logic [WEIGHT_BITS+15:0] wt_ext;
  logic [WEIGHT_BITS-1:0]  wt;

  assign ls_raddr = (state_q == ST_CTR) ? {out_row_q[RING_W-1:0], out_col_q}
                                        : {yy[RING_W-1:0], xx};
  assign ls_waddr = {in_row_q[RING_W-1:0], in_col_q};
  assign diff = (ls_rdata_q > center_q) ? ls_rdata_q - center_q : center_q - ls_rdata_q;
  assign in_acc = in_valid_i && !in_stall_o;
  assign ls_we = in_acc && (action_i == bfg_pkg::ACT_PIXEL);
  assign wt_ext = {{WEIGHT_BITS{1'b0}}, weight_i};
  assign wt = wt_ext[WEIGHT_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      ls_mem[ls_waddr] <= pixel_i;
    end
    if (in_acc && action_i == bfg_pkg::ACT_RANGE) begin
      rng_mem[table_index_i] <= wt;
    end
    if (in_acc && action_i == bfg_pkg::ACT_SPATIAL && 32'(table_index_i) < SP_DEPTH) begin
      sp_mem[table_index_i[SP_W-1:0]] <= wt;
    end
    ls_rdata_q <= ls_mem[ls_raddr];
    rng_rdata_q <= rng_mem[diff];
    sp_rdata_q <= sp_mem[ti_q];
  end

  // tap weight and its product with the pixel
  logic [WEIGHT_BITS-1:0]   tap_w;
  logic [WEIGHT_BITS+7:0]   tap_pw;
  assign tap_w = prod_q[2*WEIGHT_BITS-1:WEIGHT_BITS];
  assign tap_pw = (WEIGHT_BITS+8)'(tap_w) * (WEIGHT_BITS+8)'(ls_rdata_q);

  logic [EW_W-1:0] in_col_nx, out_col_nx;
  logic [HR_W-1:0] in_row_nx, out_row_nx;
  logic [LEAD_W-1:0] lead_base;
  assign in_col_nx = EW_W'(in_col_q) + EW_W'(1);
  assign in_row_nx = HR_W'(in_row_q) + HR_W'(1);
  assign out_col_nx = EW_W'(out_col_q) + EW_W'(1);
  assign out_row_nx = HR_W'(out_row_q) + HR_W'(1);
  assign lead_base = drain_q ? '0 : lead_q;

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      width_q <= bfg_pkg::WIDTH_RST;
      height_q <= bfg_pkg::HEIGHT_RST;
      radius_q <= bfg_pkg::RADIUS_RST;
      in_row_q <= '0;
      in_col_q <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      lead_q <= '0;
      drain_q <= 1'b0;
      dy_q <= '0;
      dx_q <= '0;
      ti_q <= '0;
      center_q <= '0;
      prod_q <= '0;
      num_q <= '0;
      den_q <= '0;
      rem_q <= '0;
      dsh_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      out_pixel_q <= '0;
      frame_last_q <= 1'b0;
    end else begin
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // configuration write restarts the frame
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          bfg_pkg::CFG_WIDTH: width_q <= cfg_data_i[bfg_pkg::WIDTH_REG_W-1:0];
          bfg_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
          bfg_pkg::CFG_RADIUS: radius_q <= cfg_data_i[bfg_pkg::RADIUS_REG_W-1:0];
          default: ;
        endcase
        if (cfg_index_i == bfg_pkg::CFG_WIDTH || cfg_index_i == bfg_pkg::CFG_HEIGHT ||
            cfg_index_i == bfg_pkg::CFG_RADIUS) begin
          in_row_q <= '0;
          in_col_q <= '0;
          out_row_q <= '0;
          out_col_q <= '0;
          lead_q <= '0;
          drain_q <= 1'b0;
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          dy_q <= '0;
          dx_q <= '0;
          ti_q <= '0;
          num_q <= '0;
          den_q <= '0;
          if (in_acc && action_i == bfg_pkg::ACT_PIXEL) begin
            // a pixel after frame end drops what is still pending
            if (drain_q) begin
              out_row_q <= '0;
              out_col_q <= '0;
              drain_q <= 1'b0;
            end
            if (in_col_nx >= eff_w) begin
              in_col_q <= '0;
              if (in_row_nx >= eff_h) begin
                in_row_q <= '0;
                drain_q <= 1'b1;
              end else begin
                in_row_q <= in_row_nx[ROW_W-1:0];
              end
            end else begin
              in_col_q <= in_col_nx[COL_W-1:0];
            end
            if (lead_base >= delay) begin
              lead_q <= lead_base;
              state_q <= ST_CTR;
            end else begin
              lead_q <= lead_base + LEAD_W'(1);
            end
          end else if (in_acc && action_i == bfg_pkg::ACT_DRAIN && drain_q) begin
            lead_q <= lead_q - LEAD_W'(1);
            state_q <= ST_CTR;
          end
        end
        ST_CTR: state_q <= ST_CTR_CAP;
        ST_CTR_CAP: begin
          center_q <= ls_rdata_q;
          state_q <= ST_TAP_DIFF;
        end
        ST_TAP_RD: state_q <= ST_TAP_DIFF;
        ST_TAP_DIFF: state_q <= ST_TAP_MUL;
        ST_TAP_MUL: begin
          prod_q <= sp_rdata_q * rng_rdata_q;
          state_q <= ST_TAP_ACC;
        end
        ST_TAP_ACC: begin
          num_q <= num_q + NUM_W'(tap_pw);
          den_q <= den_q + DEN_W'(tap_w);
          ti_q <= ti_q + SP_W'(1);
          state_q <= ST_TAP_RD;
          if (dx_q == two_r) begin
            dx_q <= '0;
            if (dy_q == two_r) begin
              state_q <= ST_DIV_INIT;
            end else begin
              dy_q <= dy_q + SIDE_W'(1);
            end
          end else begin
            dx_q <= dx_q + SIDE_W'(1);
          end
        end
        ST_DIV_INIT: begin
          // round to nearest: (num + den/2) / den; quotient fits in 9 bits
          rem_q <= REM_W'(num_q) + REM_W'(den_q >> 1);
          dsh_q <= {den_q, 8'b0};
          quo_q <= '0;
          cnt_q <= CNT_W'(QUO_W - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (rem_q >= {1'b0, dsh_q}) begin
            rem_q <= rem_q - {1'b0, dsh_q};
            quo_q <= {quo_q[QUO_W-2:0], 1'b1};
          end else begin
            quo_q <= {quo_q[QUO_W-2:0], 1'b0};
          end
          dsh_q <= dsh_q >> 1;
          if (cnt_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (den_q == '0) begin
              out_pixel_q <= '0;
            end else if (quo_q[QUO_W-1]) begin
              out_pixel_q <= 8'hFF;
            end else begin
              out_pixel_q <= quo_q[7:0];
            end
            frame_last_q <= 1'b0;
            if (out_col_nx >= eff_w) begin
              out_col_q <= '0;
              if (out_row_nx >= eff_h) begin
                out_row_q <= '0;
                drain_q <= 1'b0;
                lead_q <= '0;
                frame_last_q <= 1'b1;
              end else begin
                out_row_q <= out_row_nx[ROW_W-1:0];
              end
            end else begin
              out_col_q <= out_col_nx[COL_W-1:0];
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign frame_last_o = frame_last_q;

endmodule

// ----- dv/bilateral_filter_gray_top_test.sv -----
// Testbench for the grayscale bilateral filter: directed and random items against a predictor.
`timescale 1ns / 1ps

module bilateral_filter_gray_top_test;

  localparam int LINE_W = 1024;
  localparam int LS_ROWS = 8;          // 2*max radius + 2 rows in the ring
  localparam int SP_DEPTH = 49;        // 7x7 spatial table
  localparam int SETTLE = 260;         // covers the busy time of one item at radius 3
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 150;

  typedef struct packed {
    logic [bfg_pkg::PIXEL_W-1:0] pix;
    logic                        last;
  } filt_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [bfg_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [bfg_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [bfg_pkg::ACTION_W-1:0] action_i = '0;
  logic [bfg_pkg::INDEX_W-1:0] table_index_i = '0;
  logic [bfg_pkg::WEIGHT_IN_W-1:0] weight_i = '0;
  logic [bfg_pkg::PIXEL_W-1:0] pixel_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [bfg_pkg::PIXEL_W-1:0] out_pixel_o;
  logic frame_last_o;

  bilateral_filter_gray_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .action_i, .table_index_i, .weight_i, .pixel_i,
    .out_valid_o, .out_stall_i, .out_pixel_o, .frame_last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Filter predictor: own copy of line ring, weight tables, registers, positions
  // ---------------------------------------------------------------------------
  logic [7:0]  line_ring [LS_ROWS][LINE_W];
  logic [15:0] range_wt [256];
  logic [15:0] spatial_wt [SP_DEPTH];
  int unsigned reg_width, reg_height, reg_radius;
  int unsigned in_row, in_col, out_row, out_col;
  bit          drain_armed;
  filt_result_t filtered_q[$];

  int unsigned cycles;
  int unsigned mismatches;
  int          hold_cycles;      // long receiver hold-off, counted down by the stall process
  bit          sender_gaps;
  int unsigned stall_mode;
  int unsigned burst_left;

  function automatic int unsigned eff_width();
    if (reg_width == 0) return 1;
    return (reg_width > LINE_W) ? LINE_W : reg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (reg_height == 0) return 1;
    return (reg_height > bfg_pkg::HEIGHT_LIMIT) ? bfg_pkg::HEIGHT_LIMIT : reg_height;
  endfunction

  function automatic int unsigned eff_radius();
    return (reg_radius == 0) ? 1 : reg_radius;
  endfunction

  function automatic int unsigned clamp_pos(int v, int unsigned n);
    if (v < 0) return 0;
    if (v >= int'(n)) return n - 1;
    return unsigned'(v);
  endfunction

  function automatic void restart_frame();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    drain_armed = 0;
  endfunction

  // Weighted average at the current output position; advances the output position.
  function automatic void emit_filtered();
    int unsigned w, h, r, side, yy, xx, diff, tap;
    int dy, dx;
    logic [7:0] ctr, p;
    longint unsigned c, num, den, res;
    filt_result_t item;
    w = eff_width(); h = eff_height(); r = eff_radius(); side = 2 * r + 1;
    ctr = line_ring[out_row % LS_ROWS][out_col];
    num = 0; den = 0;
    for (dy = -int'(r); dy <= int'(r); dy++) begin
      yy = clamp_pos(int'(out_row) + dy, h) % LS_ROWS;
      for (dx = -int'(r); dx <= int'(r); dx++) begin
        xx = clamp_pos(int'(out_col) + dx, w);
        p = line_ring[yy][xx];
        diff = (p > ctr) ? p - ctr : ctr - p;
        tap = (dy + r) * side + (dx + r);
        c = (longint'(spatial_wt[tap]) * longint'(range_wt[diff])) >> 16;
        num += longint'(p) * c;
        den += c;
      end
    end
    res = (den == 0) ? 0 : (num + den / 2) / den;
    if (res > 255) res = 255;
    item.pix = res[7:0];
    item.last = 1'b0;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) begin
        out_row = 0;
        drain_armed = 0;
        item.last = 1'b1;
      end
    end
    filtered_q.push_back(item);
  endfunction

  function automatic void predict_item(bfg_pkg::action_e act, logic [7:0] idx,
                                       logic [15:0] wt, logic [7:0] px);
    int unsigned w, h, r, k, olin;
    w = eff_width(); h = eff_height(); r = eff_radius();
    case (act)
      bfg_pkg::ACT_RANGE: range_wt[idx] = wt;
      bfg_pkg::ACT_SPATIAL: if (idx < SP_DEPTH) spatial_wt[idx] = wt;
      bfg_pkg::ACT_DRAIN: if (drain_armed) emit_filtered();
      default: begin
        // a pixel while drain outputs are pending starts a new frame
        if (drain_armed) begin
          out_row = 0; out_col = 0; drain_armed = 0;
        end
        if (in_row >= h) in_row = 0;
        if (in_col >= w) in_col = 0;
        line_ring[in_row % LS_ROWS][in_col] = px;
        k = in_row * w + in_col;
        olin = out_row * w + out_col;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
          if (in_row >= h) begin
            in_row = 0;
            drain_armed = 1;
          end
        end
        if (k >= olin + r * w + r) emit_filtered();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern, long hold-off, result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 99) < 40);
        default: out_stall_i <= (cycles % 11 < 4);
      endcase
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("bilateral_filter_gray_top verification failed");
      $finish;
    end
  end

  // Sampled mid-cycle: valid and stall are stable and the item moves at the next edge.
  always @(negedge clk_i) begin
    filt_result_t exp_res;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (filtered_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pixel %0d last %0b", out_pixel_o, frame_last_o);
      end else begin
        exp_res = filtered_q.pop_front();
        if (out_pixel_o !== exp_res.pix || frame_last_o !== exp_res.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                     exp_res.pix, exp_res.last, out_pixel_o, frame_last_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge that takes the item, or later if a sender gap follows.
  task automatic send_item(bfg_pkg::action_e act, logic [7:0] idx, logic [15:0] wt,
                           logic [7:0] px);
    bit taken;
    in_valid_i <= 1'b1;
    action_i <= act;
    table_index_i <= idx;
    weight_i <= wt;
    pixel_i <= px;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    predict_item(act, idx, wt, px);
    if (burst_left > 0) burst_left--;
    if (sender_gaps && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Sender pauses until every predicted result has arrived.
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
  endtask

  // Registers change only with the block idle.
  task automatic write_reg(logic [bfg_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    wait_results();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[bfg_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bfg_pkg::CFG_WIDTH: reg_width = value & 11'h7FF;
      bfg_pkg::CFG_HEIGHT: reg_height = value & 13'h1FFF;
      default: reg_radius = value & 2'h3;
    endcase
    restart_frame();
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned r);
    write_reg(bfg_pkg::CFG_WIDTH, w);
    write_reg(bfg_pkg::CFG_HEIGHT, h);
    write_reg(bfg_pkg::CFG_RADIUS, r);
  endtask

  task automatic send_pixels(int unsigned n);
    repeat (n) send_item(bfg_pkg::ACT_PIXEL, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic drain_frame();
    while (drain_armed)
      send_item(bfg_pkg::ACT_DRAIN, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_table_load();
    int i;
    for (i = 0; i < 256; i++)
      send_item(bfg_pkg::ACT_RANGE, i[7:0],
                (i == 0) ? 16'hFFFF : (i == 255) ? 16'h0000 : 16'($urandom), 8'($urandom));
    for (i = 0; i < SP_DEPTH; i++)
      send_item(bfg_pkg::ACT_SPATIAL, i[7:0], (i == 24) ? 16'hFFFF : 16'($urandom),
                8'($urandom));
    // entries past the 7x7 table are ignored
    send_item(bfg_pkg::ACT_SPATIAL, 8'd49, 16'h0000, 8'h00);
    send_item(bfg_pkg::ACT_SPATIAL, 8'hFF, 16'h0000, 8'hFF);
  endtask

  task automatic test_small_frames();
    set_frame(1, 1, 1);                      // single pixel, comes out on a drain
    send_item(bfg_pkg::ACT_PIXEL, 8'h00, 16'hFFFF, 8'hFF);
    drain_frame();
    set_frame(3, 2, 1);
    send_item(bfg_pkg::ACT_PIXEL, 8'hFF, 16'h0000, 8'h00);
    send_item(bfg_pkg::ACT_PIXEL, 8'h00, 16'hFFFF, 8'hFF);
    send_pixels(4);
    drain_frame();
    set_frame(4, 3, 2);
    send_pixels(12);
    drain_frame();
  endtask

  task automatic test_zero_weight_sum();
    int i;
    // tiny spatial weights truncate every tap weight to zero
    for (i = 0; i < SP_DEPTH; i++) send_item(bfg_pkg::ACT_SPATIAL, i[7:0], 16'd1, 8'h00);
    set_frame(3, 3, 1);
    send_pixels(9);
    drain_frame();
    for (i = 0; i < SP_DEPTH; i++)
      send_item(bfg_pkg::ACT_SPATIAL, i[7:0], 16'($urandom), 8'h00);
  endtask

  task automatic test_drain_cases();
    set_frame(3, 3, 1);
    send_item(bfg_pkg::ACT_DRAIN, 8'h00, 16'h0000, 8'h00);   // nothing pending
    send_pixels(4);
    send_item(bfg_pkg::ACT_DRAIN, 8'h00, 16'h0000, 8'h00);   // frame not complete yet
    send_pixels(5);
    send_item(bfg_pkg::ACT_DRAIN, 8'h00, 16'h0000, 8'h00);   // one of the pending ones
    send_pixels(9);                                          // drops the rest, new frame
    drain_frame();
    send_item(bfg_pkg::ACT_DRAIN, 8'h00, 16'h0000, 8'h00);   // after the frame
  endtask

  task automatic test_register_limits();
    set_frame(0, 0, 0);                             // all read as 1
    send_pixels(2);
    drain_frame();
    set_frame(2047, 1, 0);                          // width saturates to 1024, partial frame
    send_pixels(20);
    set_frame(1024, 3, 3);                          // exact maximum width, partial frame
    send_pixels(10);
    set_frame(1, 8191, 3);                          // height saturates, partial frame
    send_pixels(30);
    set_frame(1, 4096, 2);
    send_pixels(20);
  endtask

  task automatic test_backpressure();
    set_frame(4, 4, 1);
    wait_results();
    hold_cycles = 2000;                             // outputs back up, input stalls
    send_pixels(16);
    drain_frame();
    wait_results();
  endtask

  task automatic test_random();
    int unsigned sent, n, i, stop;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0)
        set_frame($urandom_range(0, 7) == 0 ? $urandom_range(0, 2047) % 9 : $urandom_range(1, 6),
                  $urandom_range(0, 5), $urandom_range(0, 3));
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1))
            send_item(bfg_pkg::ACT_RANGE, 8'($urandom), 16'($urandom), 8'($urandom));
          else
            send_item(bfg_pkg::ACT_SPATIAL, 8'($urandom_range(0, 63)), 16'($urandom),
                      8'($urandom));
          sent++;
        end
      n = eff_width() * eff_height();
      if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 15) == 0) begin
          send_item(bfg_pkg::ACT_DRAIN, 8'($urandom), 16'($urandom), 8'($urandom));
          sent++;
        end
        send_item(bfg_pkg::ACT_PIXEL, 8'($urandom), 16'($urandom), 8'($urandom));
        sent++;
      end
      stop = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n) : n + 1;
      for (i = 0; drain_armed && i < stop; i++) begin
        send_item(bfg_pkg::ACT_DRAIN, 8'($urandom), 16'($urandom), 8'($urandom));
        sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_results();
    end
  endtask

  initial begin
    reg_width = bfg_pkg::WIDTH_RST;
    reg_height = bfg_pkg::HEIGHT_RST;
    reg_radius = bfg_pkg::RADIUS_RST;
    restart_frame();
    cycles = 0; mismatches = 0; hold_cycles = 0; stall_mode = 0;
    sender_gaps = 1; burst_left = 4;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_load();
    test_small_frames();
    test_zero_weight_sum();
    test_drain_cases();
    test_register_limits();
    test_backpressure();
    test_random();

    wait_results();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("bilateral_filter_gray_top verification clean");
    end else begin
      $display("bilateral_filter_gray_top verification failed");
    end
    $finish;
  end

endmodule
